// ----- src/priority_ticket_table_assert.svh -----
// Assertion macros for the priority ticket table.
`ifndef PRIORITY_TICKET_TABLE_ASSERT_SVH
`define PRIORITY_TICKET_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ptt_pkg.sv -----
// Package: table size, codes and the ticket entry type.
`default_nettype none
package ptt_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_TAKE   = 2'd1;
  localparam logic [1:0] FN_FINISH = 2'd2;
  localparam logic [1:0] FN_HAND   = 2'd3;

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_PROG = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_GONE = 2'd3;

  localparam logic [2:0] RC_OK    = 3'd0;
  localparam logic [2:0] RC_FULL  = 3'd1;
  localparam logic [2:0] RC_NONE  = 3'd2;
  localparam logic [2:0] RC_NOID  = 3'd3;
  localparam logic [2:0] RC_WRONG = 3'd4;

  localparam logic [15:0] MAP_RESET = 16'h7FA9;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  prio;
    logic [2:0]  dcode;
    logic [31:0] est;
    logic [31:0] fin;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/ptt_cell.sv -----
// One table cell: holds a ticket and takes its neighbor's ticket on each shift.
`default_nettype none
module ptt_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire ptt_pkg::entry_t nbr_i,
  output ptt_pkg::entry_t      entry_o
);
  import ptt_pkg::*;

  entry_t entry_q;

  // Advance the ring by one place
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= nbr_i;
    end
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

// ----- src/priority_ticket_table.sv -----
// Top level: ticket table built as a rotating ring of cells plus its sequencer.
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one operation item: add,
//  take next, finish or hand over. Output channel (out_valid_o / out_stall_i)
//  returns exactly one result item per operation. The priority map is written
//  through cfg_we_i / cfg_wdata_i; the user must do so only while the block
//  is idle, which the block itself does not enforce. Tickets live in a ring
//  of DEPTH cells that rotates one place per cycle while an item is worked
//  on; the cell at the head is examined or rewritten as it passes, and after
//  DEPTH shifts the ring is back in order. Add, finish and hand over take one
//  lap from accept to result. Take next needs a search lap and an update lap;
//  with no waiting ticket it ends after the search lap. The lap length sets
//  the item rate; one item is worked on at a time.
//  A new item is accepted while the previous result still waits in the output
//  register; if the receiver stalls, the finished item waits at the end of its
//  lap until the output register frees up.
//  Reset empties the table (count zero) and loads the default priority map;
//  cell contents are not cleared since only entries below the count are read.
`default_nettype none
module priority_ticket_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [3:0]  damage_type_i,
  input  wire logic [31:0] estimate_cost_i,
  input  wire logic [6:0]  ticket_id_i,
  input  wire logic [31:0] final_cost_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       result_code_o,
  output logic [6:0]       out_id_o,
  output logic [3:0]       out_damage_o,
  output logic [1:0]       out_priority_o,
  output logic [1:0]       out_status_o,
  output logic [31:0]      out_estimate_o,
  output logic [31:0]      out_final_o
);
  import ptt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q;
  logic [CNT_W-1:0] count_q;
  logic [15:0]      map_q;

  logic [1:0]  func_q;
  logic [2:0]  dcode_q;
  logic [31:0] est_q, fcost_q;
  logic [6:0]  id_q;

  logic             found_q, any_q, wrong_q;
  logic [IDX_W-1:0] best_q;
  logic [1:0]       bestp_q;
  entry_t           cap_q;
  logic [IDX_W-1:0] cap_idx_q;

  logic        out_valid_q;
  logic [2:0]  rc_q;
  logic [6:0]  oid_q;
  logic [3:0]  odmg_q;
  logic [1:0]  oprio_q, ostat_q;
  logic [31:0] oest_q, ofin_q;

  entry_t cell_q [DEPTH];
  entry_t ring_in;
  entry_t head;
  entry_t new_entry;
  logic   shift;

  logic       live, last, accept, fire_out;
  logic [1:0] need;
  logic       id_bad;
  logic [6:0] id_m1;
  logic       at_id, at_add, full;
  logic [1:0] map_p;
  logic       hit;
  logic [2:0] rc_d;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign shift = (state_q == S_SCAN) || (state_q == S_APPLY);
  assign head = cell_q[0];
  assign last = (cnt_q == IDX_W'(DEPTH - 1));
  assign live = (CNT_W'(cnt_q) < count_q);
  assign need = (func_q == FN_FINISH) ? ST_PROG : ST_DONE;
  assign id_bad = (id_q == 7'd0) || (id_q > 7'(count_q));
  assign id_m1 = id_q - 7'd1;
  assign at_id = !id_bad && (7'(cnt_q) == id_m1);
  assign full = (count_q == CNT_W'(DEPTH));
  assign at_add = !full && (CNT_W'(cnt_q) == count_q);
  assign fire_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign map_p = map_q[{dcode_q, 1'b0} +: 2];

  // Build the new ticket for add
  always_comb begin
    new_entry.status = ST_WAIT;
    new_entry.prio   = (map_p == 2'd0) ? 2'd3 : map_p;
    new_entry.dcode  = dcode_q;
    new_entry.est    = est_q;
    new_entry.fin    = 32'd0;
  end

  // Rewrite the head entry as it leaves for the tail cell
  always_comb begin
    ring_in = head;
    hit = 1'b0;
    if (state_q == S_SCAN) begin
      case (func_q)
        FN_ADD: begin
          if (at_add) begin
            ring_in = new_entry;
            hit = 1'b1;
          end
        end
        FN_FINISH, FN_HAND: begin
          if (at_id && head.status == need) begin
            ring_in.status = need + 2'd1;
            if (func_q == FN_FINISH) begin
              ring_in.fin = fcost_q;
            end
            hit = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_APPLY) begin
      if (cnt_q == best_q) begin
        ring_in.status = ST_PROG;
        hit = 1'b1;
      end
    end
  end

  // Ring of cells: each takes its upper neighbor, the tail takes the head
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    if (gi == DEPTH - 1) begin : g_tail
      ptt_cell u_cell (.clk_i(clk_i), .shift_i(shift), .nbr_i(ring_in), .entry_o(cell_q[gi]));
    end else begin : g_body
      ptt_cell u_cell (.clk_i(clk_i), .shift_i(shift), .nbr_i(cell_q[gi+1]),
                       .entry_o(cell_q[gi]));
    end
  end

  // Sequence the laps
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN: begin
        if (last) begin
          if (func_q == FN_TAKE && (found_q || (live && head.status == ST_WAIT))) begin
            state_d = S_APPLY;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_APPLY: if (last) state_d = S_FIN;
      S_FIN:   if (fire_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Pick the result code
  always_comb begin
    case (func_q)
      FN_ADD:  rc_d = full ? RC_FULL : RC_OK;
      FN_TAKE: rc_d = found_q ? RC_OK : RC_NONE;
      default: begin
        if (!any_q) rc_d = RC_NONE;
        else if (id_bad) rc_d = RC_NOID;
        else if (wrong_q) rc_d = RC_WRONG;
        else rc_d = RC_OK;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      map_q       <= MAP_RESET;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      wrong_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        map_q <= cfg_wdata_i;
      end
      if (shift) begin
        cnt_q <= last ? '0 : cnt_q + IDX_W'(1);
      end
      if (accept) begin
        found_q <= 1'b0;
        any_q   <= 1'b0;
        wrong_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (live && head.status == ST_WAIT && (!found_q || head.prio < bestp_q)) begin
          found_q <= 1'b1;
        end
        if (live && head.status == need) begin
          any_q <= 1'b1;
        end
        if (at_id && head.status != need) begin
          wrong_q <= 1'b1;
        end
      end
      if (fire_out) begin
        out_valid_q <= 1'b1;
        if (func_q == FN_ADD && !full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item fields, search result, captured ticket and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      dcode_q <= 3'(damage_type_i - 4'd1);
      est_q   <= estimate_cost_i;
      fcost_q <= final_cost_i;
      id_q    <= ticket_id_i;
    end
    if (state_q == S_SCAN && live && head.status == ST_WAIT &&
        (!found_q || head.prio < bestp_q)) begin
      best_q  <= cnt_q;
      bestp_q <= head.prio;
    end
    if (hit) begin
      cap_q     <= ring_in;
      cap_idx_q <= cnt_q;
    end
    if (fire_out) begin
      rc_q <= rc_d;
      if (rc_d == RC_OK) begin
        oid_q   <= 7'(cap_idx_q) + 7'd1;
        odmg_q  <= {1'b0, cap_q.dcode} + 4'd1;
        oprio_q <= cap_q.prio;
        ostat_q <= cap_q.status;
        oest_q  <= cap_q.est;
        ofin_q  <= cap_q.fin;
      end else begin
        oid_q   <= '0;
        odmg_q  <= '0;
        oprio_q <= '0;
        ostat_q <= '0;
        oest_q  <= '0;
        ofin_q  <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_code_o  = rc_q;
  assign out_id_o       = oid_q;
  assign out_damage_o   = odmg_q;
  assign out_priority_o = oprio_q;
  assign out_status_o   = ostat_q;
  assign out_estimate_o = oest_q;
  assign out_final_o    = ofin_q;

`include "priority_ticket_table_assert.svh"

  `PTT_ASSERT_NOW(a_count_max, 1'b1, count_q <= CNT_W'(DEPTH), "ticket count above depth")
  `PTT_ASSERT_NEXT(a_busy_after_accept, accept, in_stall_o, "no stall after accepting item")
  `PTT_ASSERT_NOW(a_ok_has_id, out_valid_o && result_code_o == RC_OK, out_id_o != 7'd0, "ok result without ticket id")
  `PTT_ASSERT_NOW(a_err_zero_id, out_valid_o && result_code_o != RC_OK, out_id_o == 7'd0, "error result with ticket id")

endmodule
`default_nettype wire
